// File: src/twr_pkg.sv
// Shared types and constants for the two-way ranging statistics block.
package twr_pkg;

  localparam int COUNT_WIDTH  = 32;
  localparam int NUM_OUTCOMES = 5;
  localparam int OUTCOME_W    = 3;
  localparam int KW           = 20;
  localparam int MAGW         = 60;
  localparam int PRODW        = MAGW + KW;
  localparam int QSHIFT       = 43;
  localparam int QW           = PRODW - QSHIFT;
  localparam int MUL_STEPS    = KW;
  localparam int STEP_W       = $clog2(MUL_STEPS + 1);
  localparam int ADDR_W       = 3;

  localparam logic [KW-1:0]        MM_PER_TICK_RESET = KW'(307387);
  localparam logic [OUTCOME_W-1:0] OUTCOME_SUCCESS   = 3'd0;
  localparam logic                 REG_MM_PER_TICK   = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PROD,
    ST_NUM,
    ST_MRAW,
    ST_MCOR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [31:0]          poll_sent_time;
    logic [31:0]          reply_heard_time;
    logic [31:0]          poll_heard_time;
    logic [31:0]          reply_sent_time;
    logic signed [15:0]   clock_offset;
  } item_t;

  typedef struct packed {
    logic               range_valid;
    logic signed [31:0] raw_mm;
    logic signed [31:0] cor_range_mm;
    logic [31:0]        outcome_count;
    logic [31:0]        failure_total;
    logic signed [31:0] corrected_low;
    logic signed [31:0] corrected_high;
    logic signed [15:0] offset_low;
    logic signed [15:0] offset_high;
    logic signed [63:0] raw_total;
    logic signed [63:0] corrected_total;
    logic signed [63:0] offset_total;
  } result_t;

endpackage

// File: src/twr_mul.sv
// Bit-serial shift-add multiplier: magnitude times scale, one scale bit per cycle.
module twr_mul import twr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MAGW-1:0] mag,
  input  logic [KW-1:0]   k,
  output logic            done,
  output logic [QW-1:0]   q
);

  logic [PRODW-1:0]  prod;
  logic [MAGW-1:0]   mcand;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic [MAGW:0]     sum;

  assign sum  = {1'b0, prod[PRODW-1:KW]} + (prod[0] ? {1'b0, mcand} : '0);
  assign done = run && (cnt == '0);
  assign q    = prod[PRODW-1:QSHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= STEP_W'(MUL_STEPS);
    end else if (run) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{MAGW{1'b0}}, k};
      mcand <= mag;
    end else if (run && (cnt != '0)) begin
      prod <= {sum, prod[KW-1:1]};
    end
  end

endmodule

// File: src/twr_range_with_cfo_stats.sv
// Top level: ranging math, outcome counters and running statistics.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      item_t
//  result    out        result_valid / result_stall  result_t
//  config    in         psel penable pwrite pready   paddr, pwdata, prdata
//
// A success goes through the setup states DIFF, PROD and NUM, then two passes through
// the 20-step serial multiplier, then DONE, which loads the result. A failure or
// unknown outcome goes straight from IDLE to DONE.
// One item is worked on at a time; a new one is taken while a result waits.
// rst is synchronous: counters and sums clear, extremes return to their limits.
// A stalled result holds the engine only at its final step.
module twr_range_with_cfo_stats import twr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  function automatic logic signed [31:0] sat_mm(input logic neg, input logic [QW-1:0] qv);
    logic signed [31:0] r;
    if (neg) begin
      if (qv > QW'(64'h8000_0000)) r = 32'sh8000_0000;
      else r = 32'd0 - qv[31:0];
    end else begin
      if (qv > QW'(64'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else r = qv[31:0];
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [KW-1:0] mm_per_tick;
  item_t         cur;
  logic [31:0]   ra, db;
  logic [32:0]   diff;
  logic signed [47:0] dbc;
  logic [60:0]   num_cor;
  logic [QW-1:0] raw_q, cor_q;

  logic            mul_start, mul_done;
  logic [MAGW-1:0] mul_mag;
  logic [QW-1:0]   mul_q;
  logic [32:0]     diff_mag;
  logic [60:0]     cor_abs;
  logic            load_out;

  logic [COUNT_WIDTH-1:0] counts [NUM_OUTCOMES];
  logic [COUNT_WIDTH-1:0] fail_count;
  logic [63:0]        raw_sum, cor_sum, off_sum;
  logic signed [31:0] cor_min, cor_max;
  logic signed [15:0] off_min, off_max;
  logic               seen;

  logic [COUNT_WIDTH-1:0] cnt_sel, fail_next;
  logic [63:0]        raw_sum_next, cor_sum_next, off_sum_next;
  logic signed [31:0] cor_min_next, cor_max_next;
  logic signed [15:0] off_min_next, off_max_next;
  logic               seen_next, is_success, is_known;
  logic signed [31:0] rmm, cmm;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MM_PER_TICK) ? {{(32-KW){1'b0}}, mm_per_tick} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_tick <= MM_PER_TICK_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MM_PER_TICK)) begin
      mm_per_tick <= pwdata[KW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (item.outcome == OUTCOME_SUCCESS) ? ST_DIFF : ST_DONE;
        end
      end
      ST_DIFF: state_next = ST_PROD;
      ST_PROD: state_next = ST_NUM;
      ST_NUM:  state_next = ST_MRAW;
      ST_MRAW: if (mul_done) state_next = ST_MCOR;
      ST_MCOR: if (mul_done) state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    mul_start  = (state == ST_NUM) || ((state == ST_MRAW) && mul_done);
    load_out   = (state == ST_DONE) && (!result_valid || !result_stall);
  end

  // datapath
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign cor_abs  = num_cor[60] ? (61'd0 - num_cor) : num_cor;
  assign mul_mag  = (state == ST_NUM) ? {1'b0, diff_mag, 26'b0} : cor_abs[MAGW-1:0];

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && item_valid) cur <= item;
    if (state == ST_DIFF) begin
      ra <= cur.reply_heard_time - cur.poll_sent_time;
      db <= cur.reply_sent_time - cur.poll_heard_time;
    end
    if (state == ST_PROD) begin
      diff <= {ra[31], ra} - {db[31], db};
      dbc  <= $signed(db) * cur.clock_offset;
    end
    if (state == ST_NUM) begin
      num_cor <= {{2{diff[32]}}, diff, 26'b0} + {{13{dbc[47]}}, dbc};
    end
    if ((state == ST_MRAW) && mul_done) raw_q <= mul_q;
    if ((state == ST_MCOR) && mul_done) cor_q <= mul_q;
  end

  twr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mag   (mul_mag),
    .k     (mm_per_tick),
    .done  (mul_done),
    .q     (mul_q)
  );

  // statistics update
  always_comb begin
    is_success   = (cur.outcome == OUTCOME_SUCCESS);
    is_known     = (cur.outcome < OUTCOME_W'(NUM_OUTCOMES));
    rmm          = is_success ? sat_mm(diff[32], raw_q) : 32'sd0;
    cmm          = is_success ? sat_mm(num_cor[60], cor_q) : 32'sd0;
    cnt_sel      = '0;
    for (int i = 0; i < NUM_OUTCOMES; i++) begin
      if (cur.outcome == OUTCOME_W'(i)) cnt_sel = counts[i] + 1'b1;
    end
    fail_next    = (is_known && !is_success) ? fail_count + 1'b1 : fail_count;
    raw_sum_next = raw_sum;
    cor_sum_next = cor_sum;
    off_sum_next = off_sum;
    cor_min_next = cor_min;
    cor_max_next = cor_max;
    off_min_next = off_min;
    off_max_next = off_max;
    seen_next    = seen;
    if (is_success) begin
      raw_sum_next = raw_sum + {{32{rmm[31]}}, rmm};
      cor_sum_next = cor_sum + {{32{cmm[31]}}, cmm};
      off_sum_next = off_sum + {{48{cur.clock_offset[15]}}, cur.clock_offset};
      if (cmm < cor_min) cor_min_next = cmm;
      if (cmm > cor_max) cor_max_next = cmm;
      if (cur.clock_offset < off_min) off_min_next = cur.clock_offset;
      if (cur.clock_offset > off_max) off_max_next = cur.clock_offset;
      seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OUTCOMES; i++) counts[i] <= '0;
      fail_count <= '0;
      raw_sum    <= '0;
      cor_sum    <= '0;
      off_sum    <= '0;
      cor_min    <= 32'sh7FFF_FFFF;
      cor_max    <= 32'sh8000_0000;
      off_min    <= 16'sh7FFF;
      off_max    <= 16'sh8000;
      seen       <= 1'b0;
    end else if (load_out) begin
      for (int i = 0; i < NUM_OUTCOMES; i++) begin
        if (cur.outcome == OUTCOME_W'(i)) counts[i] <= cnt_sel;
      end
      fail_count <= fail_next;
      raw_sum    <= raw_sum_next;
      cor_sum    <= cor_sum_next;
      off_sum    <= off_sum_next;
      cor_min    <= cor_min_next;
      cor_max    <= cor_max_next;
      off_min    <= off_min_next;
      off_max    <= off_max_next;
      seen       <= seen_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.range_valid     <= is_success;
      result.raw_mm          <= rmm;
      result.cor_range_mm    <= cmm;
      result.outcome_count   <= 32'(cnt_sel);
      result.failure_total   <= 32'(fail_next);
      result.corrected_low   <= seen_next ? cor_min_next : 32'sd0;
      result.corrected_high  <= seen_next ? cor_max_next : 32'sd0;
      result.offset_low      <= seen_next ? off_min_next : 16'sd0;
      result.offset_high     <= seen_next ? off_max_next : 16'sd0;
      result.raw_total       <= raw_sum_next;
      result.corrected_total <= cor_sum_next;
      result.offset_total    <= off_sum_next;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while engine not marked busy");

  a_mul_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MRAW) || (state == ST_MCOR))
    else $error("multiplier finished outside a multiply state");

  a_invalid_range_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.range_valid |-> (result.raw_mm == 0) && (result.cor_range_mm == 0))
    else $error("range nonzero on a failed exchange");

  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_valid |->
      (result.corrected_low <= result.corrected_high) && (result.offset_low <= result.offset_high))
    else $error("running minimum exceeds maximum");

endmodule

// File: tb/sv/twr_range_with_cfo_stats_tb.sv
// Testbench for twr_range_with_cfo_stats: directed and random ranging transactions checked against a predictor.
`timescale 1ns / 1ps

module twr_range_with_cfo_stats_tb import twr_pkg::*;;

  localparam int     CYCLE_LIMIT = 5_000_000;
  localparam int     MAX_REPORTS = 10;
  localparam int     CHUNK_ITEMS = 260;
  localparam longint OFFSET_ONE  = longint'(1) << 26;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_SUCCESS,
    OC_TX_START_FAIL,
    OC_TX_TIMEOUT,
    OC_RX_FAIL,
    OC_BAD_RESPONSE,
    OC_RSVD5,
    OC_RSVD6,
    OC_RSVD7
  } outcome_e;

  class range_stats_checker;
    logic [KW-1:0]      scale;
    logic [31:0]        counts [NUM_OUTCOMES];
    logic [63:0]        raw_sum, cor_sum, off_sum;
    logic signed [31:0] cor_min, cor_max;
    logic signed [15:0] off_min, off_max;
    bit                 seen_success;
    result_t            pending[$];
    int errors, n_checked, n_success, n_failure, n_ignored, n_saturated;

    function new();
      scale = MM_PER_TICK_RESET;
      foreach (counts[i]) counts[i] = '0;
      raw_sum = '0;
      cor_sum = '0;
      off_sum = '0;
      cor_min = 32'sh7FFF_FFFF;
      cor_max = 32'sh8000_0000;
      off_min = 16'sh7FFF;
      off_max = 16'sh8000;
      seen_success = 0;
    endfunction

    // trunc(num * k / 2^43), saturated to int32
    static function logic signed [31:0] ticks_to_mm(longint num, logic [KW-1:0] k);
      logic [63:0]  mag;
      logic [127:0] q;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      q = ({64'd0, mag} * {{(128 - KW){1'b0}}, k}) >> QSHIFT;
      if (num < 0) return (q > 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
      return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    function void note_exchange(item_t it);
      result_t            r;
      logic [31:0]        ra_u, db_u, fails;
      longint             ra, db, c;
      logic signed [31:0] rmm, cmm;
      r = '0;
      if (it.outcome == OC_SUCCESS) begin
        ra_u = it.reply_heard_time - it.poll_sent_time;
        db_u = it.reply_sent_time - it.poll_heard_time;
        ra = longint'($signed(ra_u));
        db = longint'($signed(db_u));
        c = longint'(it.clock_offset);
        rmm = ticks_to_mm((ra - db) * OFFSET_ONE, scale);
        cmm = ticks_to_mm(ra * OFFSET_ONE - db * (OFFSET_ONE - c), scale);
        counts[OC_SUCCESS] = counts[OC_SUCCESS] + 1;
        raw_sum = raw_sum + {{32{rmm[31]}}, rmm};
        cor_sum = cor_sum + {{32{cmm[31]}}, cmm};
        off_sum = off_sum + 64'(c);
        if (cmm < cor_min) cor_min = cmm;
        if (cmm > cor_max) cor_max = cmm;
        if (it.clock_offset < off_min) off_min = it.clock_offset;
        if (it.clock_offset > off_max) off_max = it.clock_offset;
        seen_success = 1;
        r.range_valid = 1'b1;
        r.raw_mm = rmm;
        r.cor_range_mm = cmm;
        r.outcome_count = counts[OC_SUCCESS];
        n_success++;
        if (rmm == 32'sh7FFF_FFFF || rmm == 32'sh8000_0000 ||
            cmm == 32'sh7FFF_FFFF || cmm == 32'sh8000_0000) n_saturated++;
      end else if (it.outcome < NUM_OUTCOMES) begin
        counts[it.outcome] = counts[it.outcome] + 1;
        r.outcome_count = counts[it.outcome];
        n_failure++;
      end else begin
        n_ignored++;
      end
      fails = '0;
      for (int i = 1; i < NUM_OUTCOMES; i++) fails = fails + counts[i];
      r.failure_total = fails;
      if (seen_success) begin
        r.corrected_low = cor_min;
        r.corrected_high = cor_max;
        r.offset_low = off_min;
        r.offset_high = off_max;
      end
      r.raw_total = raw_sum;
      r.corrected_total = cor_sum;
      r.offset_total = off_sum;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t result %0d %s: expected %0h, got %0h",
                   $time, n_checked, name, exp_v, act_v);
      end
    endfunction

    function void check_report(result_t act);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t unexpected result transaction", $time);
        return;
      end
      e = pending.pop_front();
      compare_field("range_valid", e.range_valid, act.range_valid);
      compare_field("raw_mm", e.raw_mm, act.raw_mm);
      compare_field("cor_range_mm", e.cor_range_mm, act.cor_range_mm);
      compare_field("outcome_count", e.outcome_count, act.outcome_count);
      compare_field("failure_total", e.failure_total, act.failure_total);
      compare_field("corrected_low", e.corrected_low, act.corrected_low);
      compare_field("corrected_high", e.corrected_high, act.corrected_high);
      compare_field("offset_low", e.offset_low, act.offset_low);
      compare_field("offset_high", e.offset_high, act.offset_high);
      compare_field("raw_total", e.raw_total, act.raw_total);
      compare_field("corrected_total", e.corrected_total, act.corrected_total);
      compare_field("offset_total", e.offset_total, act.offset_total);
      n_checked++;
    endfunction
  endclass

  logic              clk, rst;
  logic              item_valid, item_stall;
  item_t             item;
  logic              result_valid, result_stall;
  result_t           result;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  range_stats_checker stats = new();
  outcome_e failure_codes [4] = '{OC_TX_START_FAIL, OC_TX_TIMEOUT, OC_RX_FAIL, OC_BAD_RESPONSE};
  outcome_e reserved_codes [3] = '{OC_RSVD5, OC_RSVD6, OC_RSVD7};
  int cycles = 0;
  int n_scales = 1;

  twr_range_with_cfo_stats u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("twr_range_with_cfo_stats: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) stats.check_report(result);
  end

  // receiver back-pressure: modes of free flow, light, heavy and long stalls
  initial begin : receiver
    int mode, left;
    mode = 0;
    left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 9) < 7);
        default: result_stall <= ($urandom_range(0, 19) == 0) ? ~result_stall : result_stall;
      endcase
    end
  end

  function automatic item_t exchange(outcome_e oc, logic [31:0] ps, logic [31:0] rh,
                                     logic [31:0] ph, logic [31:0] rs,
                                     logic signed [15:0] c);
    item_t it;
    it.outcome = oc;
    it.poll_sent_time = ps;
    it.reply_heard_time = rh;
    it.poll_heard_time = ph;
    it.reply_sent_time = rs;
    it.clock_offset = c;
    return it;
  endfunction

  function automatic item_t random_exchange();
    int                 sel;
    logic [31:0]        ps, ph, delay, flight;
    logic signed [15:0] c;
    longint             drift;
    sel = $urandom_range(0, 99);
    c = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                    : 16'($urandom_range(0, 4000)) - 16'sd2000;
    if (sel < 55) begin
      ps = $urandom;
      ph = $urandom;
      delay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                          : $urandom_range(200, 32'h00FF_FFFF);
      flight = $urandom_range(0, 60000) - 500;
      drift = (longint'(delay) * longint'(c)) >>> 26;
      return exchange(OC_SUCCESS, ps, ps + delay + flight + 32'(drift), ph, ph + delay, c);
    end
    if (sel < 70)
      return exchange(OC_SUCCESS, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
    if (sel < 92)
      return exchange(failure_codes[$urandom_range(0, 3)], $urandom, $urandom, $urandom,
                      $urandom, 16'($urandom));
    return exchange(reserved_codes[$urandom_range(0, 2)], $urandom, $urandom, $urandom,
                    $urandom, 16'($urandom));
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    stats.note_exchange(it);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (stats.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(logic [KW-1:0] k);
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_MM_PER_TICK);
    pwdata <= 32'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    stats.scale = k;
    n_scales++;
  endtask

  task automatic run_directed();
    logic [31:0] ps, ph, dly;
    outcome_e    others [5] = '{OC_TX_TIMEOUT, OC_RX_FAIL, OC_BAD_RESPONSE, OC_RSVD6, OC_RSVD7};
    ps = 32'hFFFF_FF00;
    ph = 32'hFFFF_FFF0;
    dly = 32'h0010_0000;
    // failure and ignored code before any success
    send_item(exchange(OC_TX_START_FAIL, $urandom, $urandom, $urandom, $urandom, 16'($urandom)));
    send_item(exchange(OC_RSVD5, $urandom, $urandom, $urandom, $urandom, 16'($urandom)));
    send_item(exchange(OC_SUCCESS, '0, '0, '0, '0, 16'sd0));
    send_item(exchange(OC_SUCCESS, '1, '1, '1, '1, 16'sh8000));
    send_item(exchange(OC_SUCCESS, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0, 16'sh7FFF));
    send_item(exchange(OC_SUCCESS, '0, 32'h8000_0000, '0, 32'h7FFF_FFFF, 16'sd0));
    send_item(exchange(OC_SUCCESS, ps, ps + dly + 32'd2000, ph, ph + dly, 16'sd0));
    send_item(exchange(OC_SUCCESS, ps, ps + dly + 32'd2000, ph, ph + dly, 16'sh7FFF));
    send_item(exchange(OC_SUCCESS, ps, ps + dly + 32'd2000, ph, ph + dly, 16'sh8000));
    send_item(exchange(OC_SUCCESS, ps, ps + dly - 32'd300, ph, ph + dly, 16'sd12));
    foreach (others[i])
      send_item(exchange(others[i], $urandom, $urandom, $urandom, $urandom, 16'($urandom)));
    send_item(exchange(OC_TX_START_FAIL, '1, '1, '1, '1, 16'sh7FFF));
    send_item(exchange(OC_SUCCESS, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                       16'sh5555));
    send_item(exchange(OC_SUCCESS, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                       16'shAAAA));
    drain();
  endtask

  task automatic run_random(int n);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < n) begin
          send_item(random_exchange());
          sent++;
        end
      end
      if ($urandom_range(0, 99) < 3) drain();
      else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(CHUNK_ITEMS);
    write_scale(20'hF_FFFF);
    run_random(CHUNK_ITEMS);
    write_scale(20'd0);
    run_random(CHUNK_ITEMS);
    write_scale(KW'($urandom_range(1, 20'hF_FFFF)));
    run_random(CHUNK_ITEMS);
    write_scale(20'd1);
    run_random(CHUNK_ITEMS);
    write_scale(MM_PER_TICK_RESET);
    run_random(CHUNK_ITEMS);

    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d successes (%0d saturated), %0d failures, %0d ignored codes",
             stats.n_success, stats.n_saturated, stats.n_failure, stats.n_ignored);
    $display("over %0d scale settings: %0d results checked, %0d field mismatches",
             n_scales, stats.n_checked, stats.errors);
    if (stats.errors == 0 && stats.pending.size() == 0)
      $display("twr_range_with_cfo_stats: match");
    else
      $display("twr_range_with_cfo_stats: mismatch");
    $finish;
  end

endmodule
